// ----- rtl/mbet_pkg.sv -----
// Package for the Mandelbrot escape-time block: word types, ring item types,
// fixed-point constants and the saturation helper. No dependencies.
package mbet_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS = 26;
  localparam int ITER_BITS = 13;
  localparam int LIMIT_BITS = 12;
  localparam int STEP_BITS = 27;
  localparam int PROD_BITS = COORD_BITS + STEP_BITS;
  localparam int TAG_BITS = 2;
  localparam int TAG_SLOTS = 1 << TAG_BITS;
  localparam int OUTST_BITS = TAG_BITS + 1;

  localparam logic [7:0] RED_FULL = 8'd255;
  localparam logic [ITER_BITS-1:0] RED_COUNT_LIMIT = ITER_BITS'(500);

  localparam bit ESC_ON = (2 * FRAC_BITS + 2) < 64;
  localparam logic [63:0] ESC_LIMIT = ESC_ON ? (64'd1 << (2 * FRAC_BITS + 2)) : '1;

  typedef enum logic [2:0] {
    REG_ORIGIN_RE = 3'd0,
    REG_ORIGIN_IM = 3'd1,
    REG_STEP      = 3'd2,
    REG_MAX_ITER  = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } in_word_t;

  typedef struct packed {
    logic [ITER_BITS-1:0] iterations;
    logic [7:0]           red;
  } out_word_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic signed [31:0]   cr;
    logic signed [31:0]   ci;
    logic signed [31:0]   zr;
    logic signed [31:0]   zi;
    logic [ITER_BITS-1:0] cnt;
  } ring_item_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [ITER_BITS-1:0] cnt;
  } done_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/mbet_core.sv -----
// Three-stage iteration ring: squares and cross product, escape test and
// difference, then shift, add c and saturate. Depends on mbet_pkg.
module mbet_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            inj_v,
  input  mbet_pkg::ring_item_t            inj_item,
  input  logic [mbet_pkg::LIMIT_BITS-1:0] max_iter,
  output logic                            slot_free,
  output logic                            done_v,
  output mbet_pkg::done_item_t            done_item
);
  import mbet_pkg::*;

  logic                  a_v_r, b_v_r, c_v_r;
  logic [TAG_BITS-1:0]   a_tag_r, b_tag_r, c_tag_r;
  logic signed [31:0]    a_cr_r, a_ci_r, b_cr_r, b_ci_r, c_cr_r, c_ci_r;
  logic [ITER_BITS-1:0]  a_cnt_r, b_cnt_r, c_cnt_r;
  logic signed [63:0]    a_rr_r, a_ii_r, a_ri_r;
  logic                  b_esc_r;
  logic signed [63:0]    b_diff_r, b_ri_r;
  logic                  c_done_r;
  logic signed [31:0]    c_zr_r, c_zi_r;

  logic                  ring_v;
  ring_item_t            ring_item;
  logic [63:0]           mag_sum;
  logic                  over;

  assign slot_free = !c_v_r || c_done_r;
  assign done_v = c_v_r && c_done_r;
  assign done_item.tag = c_tag_r;
  assign done_item.cnt = c_cnt_r;

  always_comb begin
    ring_v = inj_v || (c_v_r && !c_done_r);
    if (inj_v) begin
      ring_item = inj_item;
    end else begin
      ring_item.tag = c_tag_r;
      ring_item.cr = c_cr_r;
      ring_item.ci = c_ci_r;
      ring_item.zr = c_zr_r;
      ring_item.zi = c_zi_r;
      ring_item.cnt = c_cnt_r;
    end
  end

  assign mag_sum = 64'(a_rr_r) + 64'(a_ii_r);
  assign over = b_cnt_r > ITER_BITS'(max_iter);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= ring_v;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_tag_r <= ring_item.tag;
    a_cr_r <= ring_item.cr;
    a_ci_r <= ring_item.ci;
    a_cnt_r <= ring_item.cnt;
    a_rr_r <= ring_item.zr * ring_item.zr;
    a_ii_r <= ring_item.zi * ring_item.zi;
    a_ri_r <= ring_item.zr * ring_item.zi;

    b_tag_r <= a_tag_r;
    b_cr_r <= a_cr_r;
    b_ci_r <= a_ci_r;
    b_cnt_r <= a_cnt_r;
    b_esc_r <= ESC_ON && (mag_sum >= ESC_LIMIT);
    b_diff_r <= a_rr_r - a_ii_r;
    b_ri_r <= a_ri_r;

    c_tag_r <= b_tag_r;
    c_cr_r <= b_cr_r;
    c_ci_r <= b_ci_r;
    c_cnt_r <= b_esc_r ? b_cnt_r : b_cnt_r + 1'b1;
    c_done_r <= b_esc_r || over;
    c_zr_r <= sat32((b_diff_r >>> FRAC_BITS) + 64'(b_cr_r));
    c_zi_r <= sat32((b_ri_r >>> (FRAC_BITS - 1)) + 64'(b_ci_r));
  end

endmodule

// ----- rtl/mandelbrot_escape_time_top.sv -----
// Top level of the Mandelbrot escape-time block: configuration registers,
// coordinate stages, the iteration ring and in-order result buffer.
// Depends on mbet_pkg and mbet_core.
//
//   channel   handshake            payload
//   in        start, busy          in_word  (col, row)
//   out       out_strobe           out_word (iterations, red)
//   cfg       cfg_valid, cfg_ready cfg_index, cfg_data
//
// A pixel forms c in the coordinate stages k0 and k1, then passes around the
// ring until it escapes or passes the limit, and leaves through the result buffer.
// Up to three pixels share the ring, one in each of the ring's three stages.
// Results leave in input order, one per cycle at most.
// Busy holds off start while both coordinate stages are full and no ring slot
// or result slot is free; the receiver cannot stall results.
// Reset is synchronous; it empties the ring and restores register defaults.
module mandelbrot_escape_time_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mbet_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output mbet_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import mbet_pkg::*;

  logic signed [31:0]     origin_re_r, origin_im_r;
  logic [STEP_BITS-1:0]   step_r;
  logic [LIMIT_BITS-1:0]  max_iter_r;

  logic                   k0_v_r, k1_v_r;
  logic [PROD_BITS-1:0]   k0_pre_r, k0_pim_r;
  logic signed [31:0]     k1_cr_r, k1_ci_r;

  logic [TAG_BITS-1:0]    issue_tag_r, head_tag_r;
  logic [OUTST_BITS-1:0]  outst_r;
  logic [TAG_SLOTS-1:0]   rob_v_r;
  logic [ITER_BITS-1:0]   rob_cnt_r [TAG_SLOTS];

  logic                   out_strobe_r;
  out_word_t              out_word_r;

  logic                   accept, k0_adv, inj, emit, slot_free, done_v;
  ring_item_t             inj_item;
  done_item_t             done_item;
  logic [ITER_BITS-1:0]   head_cnt;

  assign cfg_ready = 1'b1;
  assign inj = k1_v_r && slot_free && (outst_r < OUTST_BITS'(TAG_SLOTS));
  assign k0_adv = !k1_v_r || inj;
  assign busy = k0_v_r && !k0_adv;
  assign accept = start && !busy;
  assign emit = rob_v_r[head_tag_r];
  assign head_cnt = rob_cnt_r[head_tag_r];
  assign out_strobe = out_strobe_r;
  assign out_word = out_word_r;

  always_comb begin
    inj_item.tag = issue_tag_r;
    inj_item.cr = k1_cr_r;
    inj_item.ci = k1_ci_r;
    inj_item.zr = k1_cr_r;
    inj_item.zi = k1_ci_r;
    inj_item.cnt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_re_r <= -32'sd134217728;
      origin_im_r <= -32'sd88583700;
      step_r <= STEP_BITS'(336386);
      max_iter_r <= LIMIT_BITS'(100);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_ORIGIN_RE: origin_re_r <= cfg_data;
        REG_ORIGIN_IM: origin_im_r <= cfg_data;
        REG_STEP:      step_r <= cfg_data[STEP_BITS-1:0];
        REG_MAX_ITER:  max_iter_r <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k0_v_r <= 1'b0;
      k1_v_r <= 1'b0;
    end else begin
      if (accept) begin
        k0_v_r <= 1'b1;
      end else if (k0_adv) begin
        k0_v_r <= 1'b0;
      end
      if (k0_adv) begin
        k1_v_r <= k0_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k0_pre_r <= PROD_BITS'(in_word.col) * PROD_BITS'(step_r);
      k0_pim_r <= PROD_BITS'(in_word.row) * PROD_BITS'(step_r);
    end
    if (k0_adv) begin
      k1_cr_r <= sat32(64'(origin_re_r) + 64'(k0_pre_r));
      k1_ci_r <= sat32(64'(origin_im_r) + 64'(k0_pim_r));
    end
  end

  mbet_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .inj_v     (inj),
    .inj_item  (inj_item),
    .max_iter  (max_iter_r),
    .slot_free (slot_free),
    .done_v    (done_v),
    .done_item (done_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_tag_r <= '0;
      head_tag_r <= '0;
      outst_r <= '0;
      rob_v_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (inj) begin
        issue_tag_r <= issue_tag_r + 1'b1;
      end
      if (emit) begin
        head_tag_r <= head_tag_r + 1'b1;
      end
      outst_r <= outst_r + OUTST_BITS'(inj) - OUTST_BITS'(emit);
      for (int i = 0; i < TAG_SLOTS; i++) begin
        if (done_v && done_item.tag == TAG_BITS'(i)) begin
          rob_v_r[i] <= 1'b1;
        end else if (emit && head_tag_r == TAG_BITS'(i)) begin
          rob_v_r[i] <= 1'b0;
        end
      end
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (done_v) begin
      rob_cnt_r[done_item.tag] <= done_item.cnt;
    end
    out_word_r.iterations <= head_cnt;
    out_word_r.red <= (head_cnt < RED_COUNT_LIMIT && head_cnt >= ITER_BITS'(max_iter_r))
                      ? RED_FULL : 8'd0;
  end

`ifndef NO_ASSERTIONS
  a_outst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outst_r <= OUTST_BITS'(TAG_SLOTS))
    else $error("More words in flight than result slots.");

  a_slot_free_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    done_v |-> !rob_v_r[done_item.tag])
    else $error("Finished word overwrote a pending result.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_word.iterations <= ITER_BITS'(max_iter_r) + ITER_BITS'(2)))
    else $error("Iteration count exceeds the limit plus two.");

  a_emit_follows_outst: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (outst_r != '0))
    else $error("Result emitted with nothing outstanding.");
`endif

endmodule

// ----- tb/mandelbrot_escape_time_top_tb.sv -----
// Testbench for mandelbrot_escape_time_top: a directed table, then random pixels
// under many register settings, each checked against a typed row or a local predictor.
// Depends on mbet_pkg and the mandelbrot_escape_time_top RTL.
module mandelbrot_escape_time_top_tb;
  import mbet_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [26:0]        stp;
    logic [11:0]        lim;
  } view_t;

  typedef struct {
    int          view;
    logic [11:0] col;
    logic [11:0] row;
    bit          typed;
    int          iters;
    int          red;
  } pixel_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_word_t in_word;
  logic out_strobe;
  out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  view_t cur;
  out_word_t pending_px[$];
  int errors;
  int cycles;
  bit steady;

  mandelbrot_escape_time_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic out_word_t escape_count(in_word_t w);
    logic signed [31:0] cr, ci, zr, zi;
    longint rr, ii, ri;
    logic [63:0] ar, ai;
    int unsigned cnt, prev;
    out_word_t r;
    cr = clamp32(longint'(cur.re) + longint'(w.col) * longint'(cur.stp));
    ci = clamp32(longint'(cur.im) + longint'(w.row) * longint'(cur.stp));
    zr = cr;
    zi = ci;
    cnt = 0;
    while (1) begin
      ar = (zr < 0) ? 64'(-longint'(zr)) : 64'(longint'(zr));
      ai = (zi < 0) ? 64'(-longint'(zi)) : 64'(longint'(zi));
      if (ar * ar + ai * ai >= (64'd1 << (2 * FRAC_BITS + 2))) break;
      rr = longint'(zr) * longint'(zr);
      ii = longint'(zi) * longint'(zi);
      ri = longint'(zr) * longint'(zi);
      zr = clamp32(((rr - ii) >>> FRAC_BITS) + longint'(cr));
      zi = clamp32((ri >>> (FRAC_BITS - 1)) + longint'(ci));
      prev = cnt;
      cnt++;
      if (prev > cur.lim) break;
    end
    r.iterations = cnt[ITER_BITS-1:0];
    r.red = (cnt < 500 && cnt >= cur.lim) ? RED_FULL : 8'd0;
    return r;
  endfunction

  task automatic note(string what, int want, int got);
    $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_px.size() == 0) begin
        note("unexpected word", 0, 1);
      end else begin
        if (out_word.iterations !== pending_px[0].iterations)
          note("iterations", pending_px[0].iterations, out_word.iterations);
        if (out_word.red !== pending_px[0].red)
          note("red", pending_px[0].red, out_word.red);
        void'(pending_px.pop_front());
      end
    end
  end

  task automatic idle_gap();
    while (!steady && $urandom_range(99) < 25) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_pixel(logic [11:0] col, logic [11:0] row, out_word_t want, bit typed);
    in_word_t w;
    w.col = col;
    w.row = row;
    idle_gap();
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    pending_px.push_back(typed ? want : escape_count(w));
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    while ($urandom_range(99) < 25) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_view(view_t v);
    settle();
    write_reg(REG_ORIGIN_RE, v.re);
    write_reg(REG_ORIGIN_IM, v.im);
    write_reg(REG_STEP, {5'd0, v.stp});
    write_reg(REG_MAX_ITER, {20'd0, v.lim});
    cur = v;
  endtask

  view_t views[5];
  pixel_row_t plan[$];

  initial begin
    view_t v;
    out_word_t want;
    int now_view;
    int count;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ORIGIN_RE;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    steady = 1'b0;
    cur = '{re: -32'sd134217728, im: -32'sd88583700, stp: 27'd336386, lim: 12'd100};
    views[0] = cur;
    views[1] = '{re: 32'sd0, im: 32'sd0, stp: 27'd0, lim: 12'd10};
    views[2] = '{re: 32'sh7FFFFFFF, im: 32'sh7FFFFFFF, stp: 27'h4000000, lim: 12'd4095};
    views[3] = '{re: 32'sd0, im: 32'sd0, stp: 27'd0, lim: 12'd0};
    views[4] = '{re: 32'sh80000000, im: 32'sh80000000, stp: 27'h7FFFFFF, lim: 12'd1};
    plan = '{
      '{0, 12'd0, 12'd0, 0, 0, 0},
      '{0, 12'd4095, 12'd4095, 0, 0, 0},
      '{0, 12'd4095, 12'd0, 0, 0, 0},
      '{0, 12'd0, 12'd4095, 0, 0, 0},
      '{0, 12'd400, 12'd262, 0, 0, 0},
      '{0, 12'd300, 12'd262, 0, 0, 0},
      '{0, 12'd2730, 12'd1365, 0, 0, 0},
      '{1, 12'd0, 12'd0, 1, 12, 255},
      '{1, 12'd4095, 12'd4095, 1, 12, 255},
      '{2, 12'd0, 12'd0, 1, 0, 0},
      '{2, 12'd4095, 12'd4095, 1, 0, 0},
      '{3, 12'd1234, 12'd567, 1, 2, 255},
      '{4, 12'd0, 12'd0, 1, 0, 0},
      '{4, 12'd4095, 12'd4095, 0, 0, 0},
      '{4, 12'd2048, 12'd1, 0, 0, 0}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    now_view = 0;
    foreach (plan[i]) begin
      if (plan[i].view != now_view) begin
        load_view(views[plan[i].view]);
        now_view = plan[i].view;
      end
      want.iterations = plan[i].iters[ITER_BITS-1:0];
      want.red = plan[i].red[7:0];
      send_pixel(plan[i].col, plan[i].row, want, plan[i].typed);
    end

    for (int p = 0; p < 9; p++) begin
      if ($urandom_range(3) == 0) begin
        v.re = $urandom;
        v.im = $urandom;
        v.stp = 27'($urandom_range(0, 27'h7FFFFFF));
      end else begin
        v.re = -32'sd167772160 + $signed($urandom_range(0, 32'd201326592));
        v.im = -32'sd100663296 + $signed($urandom_range(0, 32'd134217728));
        v.stp = 27'($urandom_range(1, 65536));
      end
      v.lim = (p == 1) ? 12'd0 : 12'($urandom_range(1, 300));
      count = 60;
      if (p == 4) begin
        v.lim = 12'd4095;
        count = 5;
      end
      load_view(v);
      steady = (p == 2);
      for (int k = 0; k < count; k++)
        send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), '0, 1'b0);
      steady = 1'b0;
    end

    settle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- mandelbrot_escape_time_top.f -----
rtl/mbet_pkg.sv
rtl/mbet_core.sv
rtl/mandelbrot_escape_time_top.sv
tb/mandelbrot_escape_time_top_tb.sv
